/* design/tvd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the trajectory velocity difference core.
package tvd_pkg;

  localparam int unsigned PosW      = 32;
  localparam int unsigned BoxW      = 31;
  localparam int unsigned FrameW    = 16;
  localparam int unsigned AtomIdxW  = 12;
  localparam int unsigned InvW      = 32;
  localparam int unsigned DiffW     = 33;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned QuotW     = 49;
  localparam int unsigned NumStages = 6;
  localparam int unsigned InDataW   = 192;
  localparam int unsigned OutDataW  = 128;

  localparam logic [InvW-1:0] InvResetVal = 32'h0001_0000;

  typedef struct packed {
    logic [PosW-1:0] z;
    logic [PosW-1:0] y;
    logic [PosW-1:0] x;
  } pos3_t;

  typedef struct packed {
    logic [BoxW-1:0] z;
    logic [BoxW-1:0] y;
    logic [BoxW-1:0] x;
  } box3_t;

  typedef struct packed {
    logic [2:0] pad;
    box3_t      box;
    pos3_t      pos;
  } in_word_t;

  typedef struct packed {
    logic [3:0]          pad;
    logic [AtomIdxW-1:0] atom_idx;
    logic [FrameW-1:0]   frame_idx;
    pos3_t               vel;
  } out_word_t;

  typedef struct packed {
    logic [FrameW-1:0]   frame_a;
    logic [FrameW-1:0]   frame_b;
    logic [AtomIdxW-1:0] atom_idx;
    logic                emit_a;
    logic                emit_b;
    logic                last_a;
    logic                err;
  } meta_t;

  typedef struct packed {
    logic ld_c;
    logic ld_d;
    logic ld_e;
    logic ld_g;
    logic ld_h;
  } axis_ld_t;

  typedef struct packed {
    logic newer_en;
    logic older_en;
  } store_wr_t;

endpackage

/* design/trajectory_velocity_difference_core.sv */
`timescale 1ns / 1ps
// Top level: frame/atom control, position store, two velocity lanes, output register.
//
// Accepts one atom per cycle unless output back-pressure stalls the pipeline,
// and returns per-atom velocities one frame late. An item passes through seven
// register steps (store read, difference, minimum-image wrap, magnitude,
// 32x32 multiply, rounding, output register). The first step loads at the
// transfer edge. Error-free items of a frame after frame 0 marked
// end_of_trajectory carry two results (the held frame and the backward
// difference of this frame); the output port moves one result per cycle while
// m_axis_tready is high, so such an item holds the output register until both
// of its results are transferred. The position memories need no clearing pass after reset.
module trajectory_velocity_difference_core import tvd_pkg::*; #(
  parameter int unsigned MAX_ATOMS = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_wr_en_i,
  input  logic [InvW-1:0]     cfg_wr_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // pos_x, pos_y, pos_z, box_x, box_y, box_z, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  input  logic                s_axis_tlast,   // end_of_frame
  input  logic                s_axis_tuser,   // end_of_trajectory
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // vel_x, vel_y, vel_z, frame_index, atom_index, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast,   // run_last
  output logic                m_axis_tuser    // count_error
);

  localparam int unsigned CntW  = $clog2(MAX_ATOMS + 1);
  localparam int unsigned AddrW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;

  in_word_t in_w;
  logic     eof, eot, traj_end;

  logic [InvW-1:0]   inv_q;
  logic [CntW-1:0]   atom_cnt_q, atom_cnt_d;
  logic [CntW-1:0]   apf_q, apf_d;
  logic [FrameW-1:0] frame_cnt_q, frame_cnt_d;
  logic              err_lat_q, err_lat_d;
  box3_t             pbox_q, pbox_d;

  logic  frame0, bad, ok, pbc_prior, pbc_cur;
  meta_t meta_d;

  logic [NumStages-1:0] v_q;
  logic [NumStages:0]   take;
  meta_t                meta_q [NumStages];

  pos3_t            b_pos_q;
  box3_t            b_box_q, b_pbox_q;
  logic             b_pbc_a_q, b_pbc_b_q, b_older_q;
  store_wr_t        b_wr_q, wr;
  logic [AddrW-1:0] b_addr_q;

  pos3_t    newer, older, prev_a, vel_a, vel_b;
  axis_ld_t ld;

  logic      f_has_a_q, f_has_b_q, f_ready, xfer;
  pos3_t     f_vel_a_q, f_vel_b_q;
  meta_t     f_meta_q;
  out_word_t out_w;

  assign in_w     = s_axis_tdata;
  assign eof      = s_axis_tlast;
  assign eot      = s_axis_tuser;
  assign traj_end = eof && eot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= InvResetVal;
    end else if (cfg_wr_en_i) begin
      inv_q <= cfg_wr_data_i;
    end
  end

  // frame and atom bookkeeping
  always_comb begin
    frame0    = (frame_cnt_q == '0);
    if (frame0) begin
      bad = (atom_cnt_q >= CntW'(MAX_ATOMS));
    end else begin
      bad = (atom_cnt_q >= apf_q) || (eof && (CntW'(atom_cnt_q + 1'b1) != apf_q));
    end
    ok        = !err_lat_q && !bad;
    pbc_prior = (pbox_q.x != '0) && (pbox_q.y != '0) && (pbox_q.z != '0);
    pbc_cur   = (in_w.box.x != '0) && (in_w.box.y != '0) && (in_w.box.z != '0);

    meta_d.frame_a  = bad ? frame_cnt_q : FrameW'(frame_cnt_q - 1'b1);
    meta_d.frame_b  = frame_cnt_q;
    meta_d.atom_idx = AtomIdxW'(atom_cnt_q);
    meta_d.emit_a   = !err_lat_q && (bad || !frame0);
    meta_d.emit_b   = ok && !frame0 && eot;
    meta_d.last_a   = bad || !eot;
    meta_d.err      = bad;
  end

  always_comb begin
    atom_cnt_d  = atom_cnt_q;
    apf_d       = apf_q;
    frame_cnt_d = frame_cnt_q;
    err_lat_d   = err_lat_q;
    pbox_d      = pbox_q;
    if (err_lat_q || bad) begin
      if (!traj_end) begin
        err_lat_d = 1'b1;
      end
    end else if (eof) begin
      if (frame0) begin
        apf_d = CntW'(atom_cnt_q + 1'b1);
      end
      atom_cnt_d = '0;
      if (frame_cnt_q != '1) begin
        frame_cnt_d = frame_cnt_q + 1'b1;
      end
      pbox_d = in_w.box;
    end else begin
      atom_cnt_d = atom_cnt_q + 1'b1;
    end
    if (traj_end) begin
      atom_cnt_d  = '0;
      apf_d       = '0;
      frame_cnt_d = '0;
      err_lat_d   = 1'b0;
      pbox_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atom_cnt_q  <= '0;
      apf_q       <= '0;
      frame_cnt_q <= '0;
      err_lat_q   <= 1'b0;
      pbox_q      <= '0;
    end else if (take[0]) begin
      atom_cnt_q  <= atom_cnt_d;
      apf_q       <= apf_d;
      frame_cnt_q <= frame_cnt_d;
      err_lat_q   <= err_lat_d;
      pbox_q      <= pbox_d;
    end
  end

  // pipeline advance: a stage loads when it is empty or its contents are moving on
  always_comb begin
    take[NumStages] = v_q[NumStages-1] && f_ready;
    for (int k = NumStages - 1; k >= 1; k--) begin
      take[k] = v_q[k-1] && (!v_q[k] || take[k+1]);
    end
    take[0] = s_axis_tvalid && (!v_q[0] || take[1]);
  end

  assign s_axis_tready = !v_q[0] || take[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        v_q[k] <= take[k] || (v_q[k] && !take[k+1]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[0]) begin
      meta_q[0] <= meta_d;
      b_pos_q   <= in_w.pos;
      b_box_q   <= in_w.box;
      b_pbox_q  <= pbox_q;
      b_pbc_a_q <= pbc_prior;
      b_pbc_b_q <= pbc_cur;
      b_older_q <= (frame_cnt_q > FrameW'(1));
      b_wr_q    <= '{newer_en: ok, older_en: ok && !frame0};
      b_addr_q  <= atom_cnt_q[AddrW-1:0];
    end
    for (int k = 1; k < NumStages; k++) begin
      if (take[k]) begin
        meta_q[k] <= meta_q[k-1];
      end
    end
  end

  assign wr.newer_en = take[1] && b_wr_q.newer_en;
  assign wr.older_en = take[1] && b_wr_q.older_en;

  tvd_pos_store #(
    .Depth (MAX_ATOMS),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (take[0]),
    .rd_addr_i (atom_cnt_q[AddrW-1:0]),
    .wr_i      (wr),
    .wr_addr_i (b_addr_q),
    .wr_pos_i  (b_pos_q),
    .newer_o   (newer),
    .older_o   (older)
  );

  assign prev_a = b_older_q ? older : newer;
  assign ld     = '{ld_c: take[1], ld_d: take[2], ld_e: take[3], ld_g: take[4],
                    ld_h: take[5]};

  tvd_axis u_axis_ax (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.x), .prev_i (prev_a.x),
    .box_i (b_pbox_q.x), .pbc_i (b_pbc_a_q), .half_i (b_older_q), .inv_i (inv_q),
    .vel_o (vel_a.x)
  );
  tvd_axis u_axis_ay (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.y), .prev_i (prev_a.y),
    .box_i (b_pbox_q.y), .pbc_i (b_pbc_a_q), .half_i (b_older_q), .inv_i (inv_q),
    .vel_o (vel_a.y)
  );
  tvd_axis u_axis_az (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.z), .prev_i (prev_a.z),
    .box_i (b_pbox_q.z), .pbc_i (b_pbc_a_q), .half_i (b_older_q), .inv_i (inv_q),
    .vel_o (vel_a.z)
  );
  tvd_axis u_axis_bx (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.x), .prev_i (newer.x),
    .box_i (b_box_q.x), .pbc_i (b_pbc_b_q), .half_i (1'b0), .inv_i (inv_q),
    .vel_o (vel_b.x)
  );
  tvd_axis u_axis_by (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.y), .prev_i (newer.y),
    .box_i (b_box_q.y), .pbc_i (b_pbc_b_q), .half_i (1'b0), .inv_i (inv_q),
    .vel_o (vel_b.y)
  );
  tvd_axis u_axis_bz (
    .clk_i (clk_i), .ld_i (ld), .pos_i (b_pos_q.z), .prev_i (newer.z),
    .box_i (b_box_q.z), .pbc_i (b_pbc_b_q), .half_i (1'b0), .inv_i (inv_q),
    .vel_o (vel_b.z)
  );

  // output register: up to two results of one item, held until transferred
  assign xfer    = m_axis_tvalid && m_axis_tready;
  assign f_ready = !(f_has_a_q || f_has_b_q) || (m_axis_tready && (f_has_a_q ^ f_has_b_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_has_a_q <= 1'b0;
      f_has_b_q <= 1'b0;
    end else if (take[NumStages]) begin
      f_has_a_q <= meta_q[NumStages-1].emit_a;
      f_has_b_q <= meta_q[NumStages-1].emit_b;
    end else if (xfer) begin
      if (f_has_a_q) begin
        f_has_a_q <= 1'b0;
      end else begin
        f_has_b_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take[NumStages]) begin
      f_meta_q  <= meta_q[NumStages-1];
      f_vel_a_q <= meta_q[NumStages-1].err ? '0 : vel_a;
      f_vel_b_q <= vel_b;
    end
  end

  always_comb begin
    out_w.pad       = '0;
    out_w.atom_idx  = f_meta_q.atom_idx;
    out_w.frame_idx = f_has_a_q ? f_meta_q.frame_a : f_meta_q.frame_b;
    out_w.vel       = f_has_a_q ? f_vel_a_q : f_vel_b_q;
  end

  assign m_axis_tvalid = f_has_a_q || f_has_b_q;
  assign m_axis_tdata  = out_w;
  assign m_axis_tlast  = f_has_a_q ? f_meta_q.last_a : 1'b1;
  assign m_axis_tuser  = f_has_a_q && f_meta_q.err;

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("count error result without run_last");

  a_atom_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    atom_cnt_q <= CntW'(MAX_ATOMS))
    else $error("atom counter beyond store depth");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_has_a_q && f_has_b_q) |-> (!f_meta_q.last_a && !f_meta_q.err))
    else $error("first of a result pair marked last or error");

  a_apf_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_cnt_q != '0) |-> (apf_q != '0))
    else $error("frame count advanced without a frame 0 atom count");

endmodule

/* design/tvd_pos_store.sv */
`timescale 1ns / 1ps
// Position line store: newer and older frame memories with write-back forwarding.
module tvd_pos_store import tvd_pkg::*; #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  store_wr_t        wr_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  pos3_t            wr_pos_i,
  output pos3_t            newer_o,
  output pos3_t            older_o
);

  pos3_t mem_newer [Depth];
  pos3_t mem_older [Depth];

  pos3_t rd_newer_q;
  pos3_t rd_older_q;
  pos3_t fwd_newer_q;
  pos3_t fwd_older_q;
  logic  fwd_newer_q_en;
  logic  fwd_older_q_en;
  logic  addr_hit;

  assign addr_hit = (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_i.newer_en) begin
      mem_newer[wr_addr_i] <= wr_pos_i;
    end
    if (wr_i.older_en) begin
      mem_older[wr_addr_i] <= newer_o;
    end
    if (rd_en_i) begin
      rd_newer_q  <= mem_newer[rd_addr_i];
      rd_older_q  <= mem_older[rd_addr_i];
      fwd_newer_q <= wr_pos_i;
      fwd_older_q <= newer_o;
    end
  end

  // forward a write-back that lands on the entry read at the same edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_newer_q_en <= 1'b0;
      fwd_older_q_en <= 1'b0;
    end else if (rd_en_i) begin
      fwd_newer_q_en <= wr_i.newer_en && addr_hit;
      fwd_older_q_en <= wr_i.older_en && addr_hit;
    end
  end

  assign newer_o = fwd_newer_q_en ? fwd_newer_q : rd_newer_q;
  assign older_o = fwd_older_q_en ? fwd_older_q : rd_older_q;

endmodule

/* design/tvd_axis.sv */
`timescale 1ns / 1ps
// One axis datapath: difference, minimum-image wrap, magnitude, scale, round, saturate.
module tvd_axis import tvd_pkg::*; (
  input  logic            clk_i,
  input  axis_ld_t        ld_i,
  input  logic [PosW-1:0] pos_i,
  input  logic [PosW-1:0] prev_i,
  input  logic [BoxW-1:0] box_i,
  input  logic            pbc_i,
  input  logic            half_i,
  input  logic [InvW-1:0] inv_i,
  output logic [PosW-1:0] vel_o
);

  logic signed [DiffW-1:0] diff_d, diff_q;
  logic [BoxW-1:0]         box_q;
  logic                    pbc_q;
  logic                    half_c_q, half_d_q, half_e_q, half_g_q;

  logic signed [DiffW:0]   two_d, box_s, d_ext, wrap_full;
  logic signed [DiffW-1:0] wrap_q;

  logic [DiffW-1:0]        neg_full;
  logic [PosW-1:0]         mag_d, mag_q;
  logic                    neg_e_q, neg_g_q, neg_h_q;

  logic [ProdW-1:0]        prod_d, prod_q;
  logic [ProdW:0]          rnd;
  logic [QuotW-1:0]        quot_d, quot_q, lim, quot_sat;

  assign diff_d = {pos_i[PosW-1], pos_i} - {prev_i[PosW-1], prev_i};

  always_comb begin
    two_d = {diff_q, 1'b0};
    box_s = {3'b000, box_q};
    d_ext = {diff_q[DiffW-1], diff_q};
    if (pbc_q && (two_d > box_s)) begin
      wrap_full = d_ext - box_s;
    end else if (pbc_q && (two_d < -box_s)) begin
      wrap_full = d_ext + box_s;
    end else begin
      wrap_full = d_ext;
    end
  end

  assign neg_full = {DiffW{1'b0}} - wrap_q;
  assign mag_d    = wrap_q[DiffW-1] ? neg_full[PosW-1:0] : wrap_q[PosW-1:0];
  assign prod_d   = mag_q * inv_i;

  always_comb begin
    rnd = {1'b0, prod_q} + (half_g_q ? 65'h1_0000 : 65'h0_8000);
    if (half_g_q) begin
      quot_d = {1'b0, rnd[ProdW:17]};
    end else begin
      quot_d = rnd[ProdW:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_c) begin
      diff_q   <= diff_d;
      box_q    <= box_i;
      pbc_q    <= pbc_i;
      half_c_q <= half_i;
    end
    if (ld_i.ld_d) begin
      wrap_q   <= wrap_full[DiffW-1:0];
      half_d_q <= half_c_q;
    end
    if (ld_i.ld_e) begin
      mag_q    <= mag_d;
      neg_e_q  <= wrap_q[DiffW-1];
      half_e_q <= half_d_q;
    end
    if (ld_i.ld_g) begin
      prod_q   <= prod_d;
      neg_g_q  <= neg_e_q;
      half_g_q <= half_e_q;
    end
    if (ld_i.ld_h) begin
      quot_q  <= quot_d;
      neg_h_q <= neg_g_q;
    end
  end

  always_comb begin
    lim      = neg_h_q ? 49'h0_8000_0000 : 49'h0_7FFF_FFFF;
    quot_sat = (quot_q > lim) ? lim : quot_q;
    vel_o    = neg_h_q ? (32'h0 - quot_sat[PosW-1:0]) : quot_sat[PosW-1:0];
  end

endmodule
